@@ hdl/si2dd_pkg.sv @@
// Shared types and constants for the signed 64-bit to decimal digit unit.
package si2dd_pkg;

    localparam int VALUE_W    = 64;
    localparam int NUM_DIGITS = 19;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [5:0] ASCII_ZERO = 6'd48;
    localparam logic [5:0] ASCII_NINE = 6'd57;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

@@ hdl/signed_int64_to_decimal_digits_unit.sv @@
// Signed 64-bit integer to ASCII decimal digit stream, bit-serial double dabble.
// A word is taken in idle, then 64 shift steps move the magnitude into BCD.
// Leading zero digits are then dropped one per cycle, and the skip state hands over to output.
// Digits leave one per cycle while the output is not stalled.
// A new word is taken only in idle, once the last digit of the previous one has been issued.
// Reset clears the control state and the output valid; data registers are not reset.
module signed_int64_to_decimal_digits_unit
    import si2dd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [5:0]                digit_char,
    output logic                      negative,
    output logic                      last_digit
);

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [5:0]             digit_char_reg, digit_char_next;
    logic                   negative_reg, negative_next;
    logic                   last_digit_reg, last_digit_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic                   out_free;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign digit_char = digit_char_reg;
    assign negative   = negative_reg;
    assign last_digit = last_digit_reg;
    assign top_digit  = bcd_reg[BCD_W-1 -: 4];
    assign out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        bcd_next        = bcd_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        neg_next        = neg_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        digit_char_next = digit_char_reg;
        negative_next   = negative_reg;
        last_digit_next = last_digit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next     = value[VALUE_W-1];
                    mag_next     = value[VALUE_W-1] ? (~value + 1'b1) : value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next     = {mag_reg[VALUE_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    state_next   = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (top_digit == 4'd0 && dig_cnt_reg > DIG_CNT_W'(1))
                begin
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    digit_char_next = ASCII_ZERO + {2'b00, top_digit};
                    negative_next   = neg_reg;
                    last_digit_next = (dig_cnt_reg == DIG_CNT_W'(1));
                    bcd_next        = {bcd_reg[BCD_W-5:0], 4'd0};
                    dig_cnt_next    = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        bcd_reg        <= bcd_next;
        neg_reg        <= neg_next;
        digit_char_reg <= digit_char_next;
        negative_reg   <= negative_next;
        last_digit_reg <= last_digit_next;
    end

`ifndef ASSERT_OFF
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT || state_reg == S_SKIP) |-> (dig_cnt_reg != '0))
        else $error("digit count empty while digits remain");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE))
        else $error("digit outside ASCII decimal range");

    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV && bit_cnt_reg == BIT_CNT_W'(VALUE_W - 1)) |=>
        (state_reg == S_SKIP && dig_cnt_reg == DIG_CNT_W'(NUM_DIGITS)))
        else $error("conversion did not hand over to digit skip");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free && dig_cnt_reg == DIG_CNT_W'(1)) |=>
        (state_reg == S_IDLE && out_valid && last_digit))
        else $error("last digit not flagged at end of run");
`endif

endmodule

@@ tb/decimal_digit_checker.sv @@
// Checker for the decimal digit unit: predicts the digit words of each value and compares.
module decimal_digit_checker
    import si2dd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [5:0]                digit_char,
    input  logic                      negative,
    input  logic                      last_digit,
    output int                        error_count,
    output int                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0] ch;
        logic       neg;
        logic       last;
    } digit_word_t;

    digit_word_t expected_digits [$];
    int          mismatch_total = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_total++;
    endtask

    task automatic predict_digits(input logic [VALUE_W-1:0] word);
        logic [3:0]         rev [NUM_DIGITS + 1];
        logic [VALUE_W-1:0] mag;
        logic               neg;
        int                 count;
        int                 k;
        digit_word_t        w;
        neg   = word[VALUE_W-1];
        mag   = neg ? (~word + 64'd1) : word;
        count = 0;
        do begin
            rev[count] = 4'(mag % 64'd10);
            count++;
            mag = mag / 64'd10;
        end while (mag != 0);
        for (k = count - 1; k >= 0; k--) begin
            w.ch   = ASCII_ZERO + {2'b00, rev[k]};
            w.neg  = neg;
            w.last = (k == 0);
            expected_digits.push_back(w);
        end
    endtask

    always @(posedge clk) begin
        digit_word_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_digits.size() == 0) begin
                    report_mismatch($sformatf("unexpected digit word %0d", digit_char));
                end
                else begin
                    want = expected_digits.pop_front();
                    if (digit_char !== want.ch)
                        report_mismatch($sformatf("digit_char %0d, want %0d",
                                                  digit_char, want.ch));
                    if (negative !== want.neg)
                        report_mismatch($sformatf("negative %b, want %b",
                                                  negative, want.neg));
                    if (last_digit !== want.last)
                        report_mismatch($sformatf("last_digit %b, want %b",
                                                  last_digit, want.last));
                end
            end
            if (in_valid && in_ready)
                predict_digits(value);
        end
        outstanding <= expected_digits.size();
        error_count <= mismatch_total;
    end

endmodule

@@ tb/signed_int64_to_decimal_digits_unit_test.sv @@
// Testbench top for the decimal digit unit: clock, reset, stimulus, ready pattern and verdict.
module signed_int64_to_decimal_digits_unit_test
    import si2dd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  RANDOM_ITEMS = 350;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 100;
    localparam int  N_DIRECTED   = 22;

    localparam logic [VALUE_W-1:0] DIRECTED [N_DIRECTED] = '{
        64'd0,
        64'd1,
        -64'd1,
        64'd9,
        64'd10,
        -64'd10,
        64'd99,
        64'd100,
        64'h7FFF_FFFF_FFFF_FFFF,
        64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0001,
        64'd1000000000000000000,
        64'd999999999999999999,
        -64'd1000000000000000000,
        -64'd999999999999999999,
        64'd9223372036854775806,
        64'd1234567890123456789,
        -64'd1234567890123456789,
        64'hFFFF_FFFF_FFFF_FFFE,
        64'h5555_5555_5555_5555,
        64'hAAAA_AAAA_AAAA_AAAA,
        64'd4294967296
    };

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [5:0]                digit_char;
    logic                      negative;
    logic                      last_digit;

    int error_count;
    int outstanding;
    int cycle_count = 0;
    bit no_idle     = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;

    signed_int64_to_decimal_digits_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .negative   (negative),
        .last_digit (last_digit)
    );

    decimal_digit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digit_char  (digit_char),
        .negative    (negative),
        .last_digit  (last_digit),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pow10(input int k);
        logic [VALUE_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 64'd10;
        return p;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] raw;
        int                 kind;
        int                 b;
        kind = $urandom_range(0, 9);
        raw  = {$urandom, $urandom};
        case (kind)
            0, 1, 2: mag = raw;
            3, 4, 5, 6: mag = raw % pow10($urandom_range(1, 19));
            7: mag = pow10($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
            8: begin
                b   = $urandom_range(0, 63);
                mag = $urandom_range(0, 1) ? (64'd1 << b) : ((64'd1 << b) - 64'd1);
            end
            default: begin
                mag = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
                mag = mag - 64'($urandom_range(0, 3));
            end
        endcase
        return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
    endfunction

    task automatic send_word(input logic [VALUE_W-1:0] word, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= word;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial begin
        int stall;
        wait (rst_n);
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int gap;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_word(DIRECTED[i], $urandom_range(0, 17));
        in_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 100 && n < 150);
            if (n == 250)
                hold_req = 1'b1;
            if (n == 200) begin
                in_valid <= 1'b0;
                wait_drained();
            end
            gap = no_idle ? 0 : $urandom_range(0, 17);
            send_word(random_value(), gap);
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
